// ===== sv/slid_pkg.sv =====
// Shared constants, codes and types of the positional list block.
`default_nettype none
package slid_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int CNT_W    = 8;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // Result item, status in the lowest bits.
  typedef struct packed {
    logic [CNT_W-1:0]  length;
    logic [DATA_W-1:0] removed;
    logic [1:0]        status;
  } res_t;

  // One store access per cycle: one write and one read.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== sv/sequential_list_insert_delete_top.sv =====
// Top level of the bounded positional list with insert, delete and modify.
// Sequencing: a modify or rejected request goes from idle to the done state and then to
//   the output register; an insert at position p shifts the entries from the tail down to
//   p up one place and then writes the value, a delete at p shifts those above p down.
//   Items are taken one at a time; each shift step does one read and one write per cycle.
// Reset (rst_n low, synchronous): clears the count, sequencer and output valid;
//   store contents are not cleared, only entries below the count are ever read.
`default_nettype none
module sequential_list_insert_delete_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // [1:0] op, [9:2] position, [41:10] value, [47:42] zero
  input  wire logic [slid_pkg::IN_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [1:0] status, [33:2] removed_value, [41:34] list_length, [47:42] zero
  output logic      [slid_pkg::OUT_W-1:0] out_tdata
);
  import slid_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_tvalid_r;
  res_t              out_res_r;

  // Sequencer owns the count and walks the store for each item.
  slid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (in_tdata[1:0]),
    .req_pos   (in_tdata[9:2]),
    .req_val   (in_tdata[41:10]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Element store: one write and one registered read each cycle.
  slid_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Output register: load a finished result when the slot is free or drains now.
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_W - $bits(res_t)){1'b0}}, out_res_r};

  // Length never exceeds the capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res_r.length <= CNT_W'(CAPACITY)))
    else $error("list length above capacity");

  // A full rejection only happens on a full list.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.status == STAT_FULL) |-> (out_res_r.length == CNT_W'(CAPACITY)))
    else $error("full status with list not full");

  // A nonzero removed value only comes with a successful request.
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.removed != '0) |-> (out_res_r.status == STAT_DONE))
    else $error("removed value on failed request");

  // One item at a time: an accepted item blocks the input next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

endmodule
`default_nettype wire

// ===== sv/slid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module slid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/slid_ctrl.sv =====
// Sequencer: request decode, store shifting and element count.
`default_nettype none
module slid_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire logic [1:0]                    req_op,
  input  wire logic [slid_pkg::POS_W-1:0]    req_pos,
  input  wire logic [slid_pkg::DATA_W-1:0]   req_val,
  output slid_pkg::mem_req_t                 mem_req,
  input  wire logic [slid_pkg::DATA_W-1:0]   mem_rdata,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output slid_pkg::res_t                     res
);
  import slid_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_INS_SHIFT = 6'b000010,
    S_INS_PUT   = 6'b000100,
    S_DEL_FIRST = 6'b001000,
    S_DEL_SHIFT = 6'b010000,
    S_DONE      = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [DATA_W-1:0] removed_r, removed_nxt;

  logic              pos_nz;
  logic              ins_ok;
  logic              del_ok;
  logic              ins_tail;
  logic [ADDR_W-1:0] in_idx;
  logic              del_last;

  assign pos_nz   = (req_pos != '0);
  assign ins_ok   = pos_nz && ({1'b0, req_pos} <= ({1'b0, count_r} + 9'd1));
  assign del_ok   = pos_nz && (req_pos <= count_r);
  assign ins_tail = ({1'b0, req_pos} == ({1'b0, count_r} + 9'd1));
  assign in_idx   = ADDR_W'(req_pos - 1'b1);
  assign del_last = ((CNT_W'(k_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = '0;
    mem_req.wdata = '0;
    mem_req.raddr = '0;
    req_ready     = (state_r == S_IDLE);
    res_valid     = (state_r == S_DONE);

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          val_nxt     = req_val;
          idx_nxt     = in_idx;
          removed_nxt = '0;
          status_nxt  = STAT_BADPOS;
          state_nxt   = S_DONE;
          case (req_op)
            OP_INSERT: begin
              if (ins_ok) begin
                if (count_r >= CNT_W'(CAPACITY)) begin
                  status_nxt = STAT_FULL;
                end else if (ins_tail) begin
                  state_nxt = S_INS_PUT;
                end else begin
                  mem_req.raddr = ADDR_W'(count_r - 1'b1);
                  k_nxt         = ADDR_W'(count_r - 1'b1);
                  state_nxt     = S_INS_SHIFT;
                end
              end
            end
            OP_DELETE: begin
              if (del_ok) begin
                mem_req.raddr = in_idx;
                k_nxt         = in_idx;
                state_nxt     = S_DEL_FIRST;
              end
            end
            OP_MODIFY: begin
              if (del_ok) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = in_idx;
                mem_req.wdata = req_val;
                status_nxt    = STAT_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        // move entry k up one place, fetch the one below it
        mem_req.we    = 1'b1;
        mem_req.waddr = k_r + 1'b1;
        mem_req.wdata = mem_rdata;
        if (k_r == idx_r) begin
          state_nxt = S_INS_PUT;
        end else begin
          k_nxt         = k_r - 1'b1;
          mem_req.raddr = k_r - 1'b1;
        end
      end

      S_INS_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = val_r;
        count_nxt     = count_r + 1'b1;
        status_nxt    = STAT_DONE;
        state_nxt     = S_DONE;
      end

      S_DEL_FIRST, S_DEL_SHIFT: begin
        if (state_r == S_DEL_FIRST) begin
          removed_nxt = mem_rdata;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = k_r - 1'b1;
          mem_req.wdata = mem_rdata;
        end
        if (del_last) begin
          count_nxt  = count_r - 1'b1;
          status_nxt = STAT_DONE;
          state_nxt  = S_DONE;
        end else begin
          k_nxt         = k_r + 1'b1;
          mem_req.raddr = k_r + 1'b1;
          state_nxt     = S_DEL_SHIFT;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  assign res.status  = status_r;
  assign res.removed = removed_r;
  assign res.length  = count_r;

endmodule
`default_nettype wire
